// ===== src/stunbr_pkg.sv =====
// stunbr_pkg: shared types and constants for the STUN binding response parser.
// Used by stunbr_front, stunbr_fifo, stunbr_back and the top level.
`timescale 1ns / 1ps
`default_nettype none

package stunbr_pkg;

	// Width of the byte position counter (17..32)
	localparam int POS_W = 17;

	// Classified beat queue between front and back, power-of-two depth
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

	localparam int HDR_LEN       = 20;
	localparam int HDR_LAST_POS  = HDR_LEN - 1;

	localparam logic [7:0]  MSG_TYPE_BYTE = 8'h01;
	localparam logic [7:0]  COOKIE_B0     = 8'h21;
	localparam logic [7:0]  COOKIE_B1     = 8'h12;
	localparam logic [7:0]  COOKIE_B2     = 8'hA4;
	localparam logic [7:0]  COOKIE_B3     = 8'h42;
	localparam logic [15:0] XMA_TYPE      = 16'h0020;
	localparam logic [15:0] XMA_MIN_LEN   = 16'd8;
	localparam logic [7:0]  FAMILY_IPV4   = 8'h01;

	typedef struct packed {
		logic [7:0]       data;
		logic             last;
		logic [POS_W-1:0] pos;
		logic             attr;    // byte lies in the attribute area of a good header
		logic             hdr_ok;  // header good and long enough, as of this byte
	} beat_t;

endpackage

`default_nettype wire

// ===== src/stunbr_front.sv =====
// stunbr_front: accepts datagram bytes, tracks position, checks the header
// and tags each beat for the back end. Depends on stunbr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stunbr_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire logic [7:0]        byte_in,
	input  wire logic              last_byte,
	input  wire logic              fifo_full,
	output logic                   beat_push,
	output stunbr_pkg::beat_t      beat
);

	localparam logic [stunbr_pkg::POS_W-1:0] POS_MAX  = {stunbr_pkg::POS_W{1'b1}};
	localparam logic [stunbr_pkg::POS_W-1:0] HDR_END  = stunbr_pkg::POS_W'(stunbr_pkg::HDR_LEN);
	localparam logic [stunbr_pkg::POS_W-1:0] HDR_LASTP =
		stunbr_pkg::POS_W'(stunbr_pkg::HDR_LAST_POS);

	logic [stunbr_pkg::POS_W-1:0] pos_q;
	logic [stunbr_pkg::POS_W-1:0] msg_end_q;
	logic                         hdr_valid_q;

	logic [stunbr_pkg::POS_W-1:0] msg_end_n;
	logic                         hdr_valid_n;
	logic                         in_hdr;

	assign full      = fifo_full;
	assign beat_push = push & ~fifo_full;
	assign in_hdr    = pos_q < HDR_END;

	always_comb begin
		hdr_valid_n = hdr_valid_q;
		msg_end_n   = msg_end_q;
		if (in_hdr) begin
			case (pos_q)
				stunbr_pkg::POS_W'(0), stunbr_pkg::POS_W'(1): begin
					if (byte_in != stunbr_pkg::MSG_TYPE_BYTE) hdr_valid_n = 1'b0;
				end
				stunbr_pkg::POS_W'(2): begin
					msg_end_n = HDR_END + stunbr_pkg::POS_W'({byte_in, 8'h00});
				end
				stunbr_pkg::POS_W'(3): begin
					msg_end_n = msg_end_q + stunbr_pkg::POS_W'(byte_in);
				end
				stunbr_pkg::POS_W'(4): begin
					if (byte_in != stunbr_pkg::COOKIE_B0) hdr_valid_n = 1'b0;
				end
				stunbr_pkg::POS_W'(5): begin
					if (byte_in != stunbr_pkg::COOKIE_B1) hdr_valid_n = 1'b0;
				end
				stunbr_pkg::POS_W'(6): begin
					if (byte_in != stunbr_pkg::COOKIE_B2) hdr_valid_n = 1'b0;
				end
				stunbr_pkg::POS_W'(7): begin
					if (byte_in != stunbr_pkg::COOKIE_B3) hdr_valid_n = 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		beat.data   = byte_in;
		beat.last   = last_byte;
		beat.pos    = pos_q;
		beat.attr   = hdr_valid_q & ~in_hdr & (pos_q < msg_end_q);
		beat.hdr_ok = hdr_valid_n & (pos_q >= HDR_LASTP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			hdr_valid_q <= 1'b1;
			msg_end_q   <= HDR_END;
		end else if (beat_push) begin
			if (last_byte) begin
				pos_q       <= '0;
				hdr_valid_q <= 1'b1;
				msg_end_q   <= HDR_END;
			end else begin
				if (pos_q != POS_MAX) pos_q <= pos_q + 1'b1;
				hdr_valid_q <= hdr_valid_n;
				msg_end_q   <= msg_end_n;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/stunbr_fifo.sv =====
// stunbr_fifo: short queue of classified beats between front and back.
// Depends on stunbr_pkg (beat_t, FIFO_DEPTH).
`timescale 1ns / 1ps
`default_nettype none

module stunbr_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire stunbr_pkg::beat_t wr_data,
	output logic                   full,
	input  wire logic              rd_en,
	output stunbr_pkg::beat_t      rd_data,
	output logic                   empty
);

	localparam logic [stunbr_pkg::FIFO_AW:0] DEPTH = (stunbr_pkg::FIFO_AW + 1)'(stunbr_pkg::FIFO_DEPTH);

	stunbr_pkg::beat_t               entry_q [stunbr_pkg::FIFO_DEPTH];
	logic [stunbr_pkg::FIFO_AW-1:0]  wr_ptr_q;
	logic [stunbr_pkg::FIFO_AW-1:0]  rd_ptr_q;
	logic [stunbr_pkg::FIFO_AW:0]    cnt_q;
	logic                            do_wr;
	logic                            do_rd;

	assign full    = cnt_q == DEPTH;
	assign empty   = cnt_q == '0;
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) entry_q[wr_ptr_q] <= wr_data;
	end

endmodule

`default_nettype wire

// ===== src/stunbr_back.sv =====
// stunbr_back: walks attributes, un-XORs XOR-MAPPED-ADDRESS and holds the
// result until popped. Depends on stunbr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stunbr_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire stunbr_pkg::beat_t beat,
	input  wire logic              beat_valid,
	output logic                   beat_pop,
	input  wire logic              pop,
	output logic                   empty,
	output logic                   success,
	output logic [15:0]            mapped_port,
	output logic [31:0]            mapped_address
);

	localparam int PW = stunbr_pkg::POS_W;
	localparam logic [PW-1:0] HDR_END = PW'(stunbr_pkg::HDR_LEN);

	logic [PW-1:0] attr_start_q, attr_start_n;
	logic [15:0]   type_q, type_n;
	logic [15:0]   len_q, len_n;
	logic [7:0]    fam_q, fam_n;
	logic [15:0]   cport_q, cport_n;
	logic [31:0]   caddr_q, caddr_n;
	logic          found_q, found_n;
	logic [15:0]   fport_q, fport_n;
	logic [31:0]   faddr_q, faddr_n;

	logic          res_valid_q;
	logic          res_success_q;
	logic [15:0]   res_port_q;
	logic [31:0]   res_addr_q;

	logic [PW-1:0] k;
	logic [PW:0]   value_end;
	logic [PW:0]   next_start;
	logic [PW:0]   pos_inc;
	logic          out_pop;
	logic          ok;

	assign out_pop  = pop & res_valid_q;
	assign beat_pop = beat_valid & (~beat.last | ~res_valid_q | out_pop);
	assign k        = beat.pos - attr_start_q;
	assign pos_inc  = {1'b0, beat.pos} + 1'b1;

	always_comb begin
		attr_start_n = attr_start_q;
		type_n       = type_q;
		len_n        = len_q;
		fam_n        = fam_q;
		cport_n      = cport_q;
		caddr_n      = caddr_q;
		found_n      = found_q;
		fport_n      = fport_q;
		faddr_n      = faddr_q;
		value_end    = '0;
		next_start   = '0;
		if (beat.attr) begin
			case (k)
				PW'(0):  type_n = {beat.data, 8'h00};
				PW'(1):  type_n = {type_q[15:8], beat.data};
				PW'(2):  len_n = {beat.data, 8'h00};
				PW'(3):  len_n = {len_q[15:8], beat.data};
				PW'(5):  fam_n = beat.data;
				PW'(6):  cport_n = {beat.data ^ stunbr_pkg::COOKIE_B0, 8'h00};
				PW'(7):  cport_n = {cport_q[15:8], beat.data ^ stunbr_pkg::COOKIE_B1};
				PW'(8):  caddr_n = {beat.data ^ stunbr_pkg::COOKIE_B0, 24'h0};
				PW'(9):  caddr_n = {caddr_q[31:24], beat.data ^ stunbr_pkg::COOKIE_B1, 16'h0};
				PW'(10): caddr_n = {caddr_q[31:16], beat.data ^ stunbr_pkg::COOKIE_B2, 8'h00};
				PW'(11): caddr_n = {caddr_q[31:8], beat.data ^ stunbr_pkg::COOKIE_B3};
				default: begin
				end
			endcase
			if (k >= PW'(3)) begin
				value_end  = {1'b0, attr_start_q} + (PW + 1)'(4) + (PW + 1)'(len_n);
				next_start = value_end + (PW + 1)'(3);
				next_start[1:0] = 2'b00;
				if (k >= PW'(4) && pos_inc == value_end && type_n == stunbr_pkg::XMA_TYPE
						&& len_n >= stunbr_pkg::XMA_MIN_LEN
						&& fam_n == stunbr_pkg::FAMILY_IPV4) begin
					found_n = 1'b1;
					fport_n = cport_n;
					faddr_n = caddr_n;
				end
				// value padded to a 4-byte boundary: next attribute starts here
				if (pos_inc == next_start) attr_start_n = pos_inc[PW-1:0];
			end
		end
	end

	assign ok = beat.hdr_ok & found_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_start_q <= HDR_END;
			type_q       <= '0;
			len_q        <= '0;
			fam_q        <= '0;
			cport_q      <= '0;
			caddr_q      <= '0;
			found_q      <= 1'b0;
			fport_q      <= '0;
			faddr_q      <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (beat_pop) begin
				if (beat.last) begin
					attr_start_q <= HDR_END;
					type_q       <= '0;
					len_q        <= '0;
					fam_q        <= '0;
					cport_q      <= '0;
					caddr_q      <= '0;
					found_q      <= 1'b0;
					fport_q      <= '0;
					faddr_q      <= '0;
				end else begin
					attr_start_q <= attr_start_n;
					type_q       <= type_n;
					len_q        <= len_n;
					fam_q        <= fam_n;
					cport_q      <= cport_n;
					caddr_q      <= caddr_n;
					found_q      <= found_n;
					fport_q      <= fport_n;
					faddr_q      <= faddr_n;
				end
			end
			if (beat_pop && beat.last) begin
				res_valid_q <= 1'b1;
			end else if (out_pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (beat_pop && beat.last) begin
			res_success_q <= ok;
			res_port_q    <= ok ? fport_n : 16'h0;
			res_addr_q    <= ok ? faddr_n : 32'h0;
		end
	end

	assign empty          = ~res_valid_q;
	assign success        = res_success_q;
	assign mapped_port    = res_port_q;
	assign mapped_address = res_addr_q;

endmodule

`default_nettype wire

// ===== src/stun_binding_response_parser_top.sv =====
// Latency: a result shows (empty low) once its last byte has gone through the
// beat queue and been caught in the result register.
// Throughput: one byte per cycle; a held result stalls the back end only at
// the next datagram's last byte, and full rises once the 2-entry beat queue fills.
// Reset (arst_n low) empties the queue and result slot and restarts parsing.
`timescale 1ns / 1ps
`default_nettype none

module stun_binding_response_parser_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  byte_in,
	input  wire logic        last_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic             success,
	output logic [15:0]      mapped_port,
	output logic [31:0]      mapped_address
);

	stunbr_pkg::beat_t front_beat;
	stunbr_pkg::beat_t back_beat;
	logic              beat_push;
	logic              beat_pop;
	logic              q_full;
	logic              q_empty;

	stunbr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.byte_in   (byte_in),
		.last_byte (last_byte),
		.fifo_full (q_full),
		.beat_push (beat_push),
		.beat      (front_beat)
	);

	stunbr_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (beat_push),
		.wr_data (front_beat),
		.full    (q_full),
		.rd_en   (beat_pop),
		.rd_data (back_beat),
		.empty   (q_empty)
	);

	stunbr_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.beat           (back_beat),
		.beat_valid     (~q_empty),
		.beat_pop       (beat_pop),
		.pop            (pop),
		.empty          (empty),
		.success        (success),
		.mapped_port    (mapped_port),
		.mapped_address (mapped_address)
	);

endmodule

`default_nettype wire

// ===== src/stunbr_checker.sv =====
// stunbr_checker: port-level assertions for the parser top level, and the
// bind that attaches them. Sees only top-level ports.
`timescale 1ns / 1ps
`default_nettype none

module stunbr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        push,
	input wire logic        full,
	input wire logic        empty,
	input wire logic        pop,
	input wire logic        success,
	input wire logic [15:0] mapped_port,
	input wire logic [31:0] mapped_address
);

	// a failed parse reports zero port and address
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !success) |-> (mapped_port == 16'h0 && mapped_address == 32'h0))
		else $error("failed result with nonzero port or address");

	// the beat queue only fills on a push
	a_full_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full rose without a push");

	// a waiting result is never dropped
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(empty) |-> $past(pop))
		else $error("result vanished without a pop");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> ($stable(success) && $stable(mapped_port)
			&& $stable(mapped_address)))
		else $error("waiting result changed");

endmodule

bind stun_binding_response_parser_top stunbr_checker u_stunbr_checker (.*);

`default_nettype wire
